// File: design/sre_pkg.sv
// shared types and constants for the spawn rate estimator
`timescale 1ns / 1ps

package sre_pkg;

    localparam int DVD_W = 96;  // dividend and quotient width of the serial divider
    localparam int DVS_W = 64;  // divisor width
    localparam int MUL_W = 40;  // operand width of the serial multiplier
    localparam int CNT_W = 7;   // step count width, holds up to DVD_W

    // request from the sequencer to a serial unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } sre_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_TACC,
        ST_WDIV,
        ST_ML,
        ST_MULC,
        ST_MULL,
        ST_A,
        ST_RATE,
        ST_LIFE,
        ST_VOL,
        ST_DONE
    } sre_state_t;

endpackage

// File: design/sre_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sre_div import sre_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  sre_op_t          req,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   rcat;
    logic [DVS_W:0]   diff;
    logic             ge;

    // dividend arrives left aligned, nbits steps consume its top bits
    assign rcat = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff = rcat - {1'b0, divisor};
    assign ge   = rcat >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= req.nbits;
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DVS_W-1:0] : rcat[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/sre_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module sre_mul import sre_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  sre_op_t            req,
    input  logic [MUL_W-1:0]   op_a,
    input  logic [MUL_W-1:0]   op_b,
    output logic               done,
    output logic [2*MUL_W-1:0] product
);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [2*MUL_W-1:0] acc_reg;
    logic [2*MUL_W-1:0] ash_reg;
    logic [MUL_W-1:0]   bsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= req.nbits;
            acc_reg <= '0;
            ash_reg <= {{MUL_W{1'b0}}, op_a};
            bsh_reg <= op_b;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (bsh_reg[0]) begin
                acc_reg <= acc_reg + ash_reg;
            end
            ash_reg <= {ash_reg[2*MUL_W-2:0], 1'b0};
            bsh_reg <= {1'b0, bsh_reg[MUL_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: design/sre_hist.sv
// sample history: shift on push, one indexed read, slot zero is the open interval
`timescale 1ns / 1ps

module sre_hist import sre_pkg::*; #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                             aclk,
    input  logic                             push,
    input  logic [31:0]                      push_interval,
    input  logic [15:0]                      push_count,
    input  logic [39:0]                      push_life,
    input  logic [31:0]                      open_interval,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_idx,
    output logic [31:0]                      rd_interval,
    output logic [15:0]                      rd_count,
    output logic [39:0]                      rd_life
);

    logic [31:0] iv_reg  [1:HISTORY_DEPTH-1];
    logic [15:0] cnt_reg [HISTORY_DEPTH];
    logic [39:0] life_reg[HISTORY_DEPTH];

    always_ff @(posedge aclk) begin
        if (push) begin
            // closed interval lands in slot one, older ones move down
            iv_reg[1]   <= push_interval;
            cnt_reg[0]  <= push_count;
            life_reg[0] <= push_life;
            for (int k = 2; k < HISTORY_DEPTH; k++) begin
                iv_reg[k] <= iv_reg[k-1];
            end
            for (int k = 1; k < HISTORY_DEPTH; k++) begin
                cnt_reg[k]  <= cnt_reg[k-1];
                life_reg[k] <= life_reg[k-1];
            end
        end
    end

    assign rd_interval = (rd_idx == '0) ? open_interval : iv_reg[rd_idx];
    assign rd_count    = cnt_reg[rd_idx];
    assign rd_life     = life_reg[rd_idx];

endmodule

// File: design/spawn_rate_estimator.sv
// spawn rate estimator top level: sequencer, accumulators and result register
//
//  channel   ports                                              direction
//  s_        elapsed_time, spawned_count, lifetime_total        in, one request per tick
//  m_        rate/life/volume_estimate, estimate_valid, saturated  out, one per request
//
// one request at a time; s_ready is high only while the sequencer is idle
// work per request: under two samples straight to done; otherwise sum, mean, then per
//   weighted sample weight and lifetime divides and two multiplies, then rate, life and volume,
//   on the bit-serial divider (one quotient bit a cycle) and shift-add multiplier
// a finished result waits in the output register, the next request is taken meanwhile
// aresetn is synchronous: history empty, open interval zero, no result pending
`timescale 1ns / 1ps

module spawn_rate_estimator import sre_pkg::*; #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_elapsed_time,
    input  logic [15:0] s_spawned_count,
    input  logic [39:0] s_lifetime_total,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [39:0] m_rate_estimate,
    output logic [31:0] m_life_estimate,
    output logic [31:0] m_volume_estimate,
    output logic        m_estimate_valid,
    output logic        m_saturated
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int HW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = 32 + IW;

    // saturating 64 bit add, top bit flags the clamp
    function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {1'b1, {64{1'b1}}} : s;
    endfunction

    sre_state_t state_reg, state_next;

    logic          pend_reg,  pend_next;
    logic [IW-1:0] idx_reg,   idx_next;
    logic [HW-1:0] held_reg,  held_next;
    logic [31:0]   open_reg,  open_next;
    logic          sat_reg,   sat_next;
    logic          est_reg,   est_next;
    logic [SW-1:0] sum_reg,   sum_next;
    logic [31:0]   mean_reg,  mean_next;
    logic [SW-1:0] tsum_reg,  tsum_next;
    logic [32:0]   w_reg,     w_next;
    logic [39:0]   ml_reg,    ml_next;
    logic [63:0]   wsum_reg,  wsum_next;
    logic [63:0]   rsum_reg,  rsum_next;
    logic [63:0]   lsum_reg,  lsum_next;
    logic [63:0]   a_reg,     a_next;
    logic [39:0]   rate_reg,  rate_next;
    logic [31:0]   life_reg,  life_next;
    logic [31:0]   vol_reg,   vol_next;

    logic          m_valid_reg;
    logic [39:0]   out_rate_reg;
    logic [31:0]   out_life_reg;
    logic [31:0]   out_vol_reg;
    logic          out_est_reg;
    logic          out_sat_reg;

    // serial units
    sre_op_t            div_req, mul_req;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic               mul_done;
    logic [2*MUL_W-1:0] mul_p;
    logic               unit_done;

    // history read
    logic [31:0] rd_interval;
    logic [15:0] rd_count;
    logic [39:0] rd_life;

    // request side
    logic          accept;
    logic          push;
    logic [32:0]   t_sum;
    logic          t_ovf;
    logic [31:0]   t_sat;
    logic [HW-1:0] held_after;
    logic          idx_last;
    logic [SW-1:0] tsum_new;
    logic          out_free;

    assign accept     = s_valid && s_ready;
    assign push       = accept && (s_spawned_count != '0);
    assign t_sum      = {1'b0, open_reg} + {9'b0, s_elapsed_time};
    assign t_ovf      = t_sum[32];
    assign t_sat      = t_ovf ? 32'hFFFF_FFFF : t_sum[31:0];
    assign held_after = (s_spawned_count == '0) ? held_reg :
                        (held_reg == HW'(HISTORY_DEPTH)) ? held_reg : held_reg + HW'(1);
    assign idx_last   = (HW'(idx_reg) + HW'(1)) == held_reg;
    assign tsum_new   = tsum_reg + SW'(rd_interval);
    assign unit_done  = div_done || mul_done;
    assign out_free   = !m_valid_reg || m_ready;

    sre_hist #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .aclk         (aclk),
        .push         (push),
        .push_interval(t_sat),
        .push_count   (s_spawned_count),
        .push_life    (s_lifetime_total),
        .open_interval(open_reg),
        .rd_idx       (idx_reg),
        .rd_interval  (rd_interval),
        .rd_count     (rd_count),
        .rd_life      (rd_life)
    );

    sre_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .done    (div_done),
        .quotient(div_q)
    );

    sre_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mul_req),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .product(mul_p)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (held_after > HW'(1)) ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM:  if (idx_last) state_next = ST_MEAN;
            ST_MEAN: if (unit_done) state_next = ST_TACC;
            ST_TACC: state_next = (tsum_new == '0) ? ST_ML : ST_WDIV;
            ST_WDIV: if (unit_done) state_next = ST_ML;
            ST_ML: begin
                if (rd_count == '0 || unit_done) state_next = ST_MULC;
            end
            ST_MULC: if (unit_done) state_next = ST_MULL;
            ST_MULL: begin
                if (unit_done) state_next = idx_last ? ST_A : ST_TACC;
            end
            ST_A: begin
                if (wsum_reg == '0) state_next = ST_DONE;
                else if (unit_done) state_next = ST_RATE;
            end
            ST_RATE: begin
                if (mean_reg == '0 || unit_done) state_next = ST_LIFE;
            end
            ST_LIFE: if (unit_done) state_next = ST_VOL;
            ST_VOL:  if (unit_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // unit requests and operands
    always_comb begin
        s_ready       = 1'b0;
        div_req.start = 1'b0;
        div_req.nbits = CNT_W'(DVD_W);
        div_dvd       = '0;
        div_dvs       = '0;
        mul_req.start = 1'b0;
        mul_req.nbits = CNT_W'(MUL_W);
        mul_a         = {7'b0, w_reg};
        mul_b         = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_MEAN: begin
                // mean of the older intervals
                div_req.start = !pend_reg;
                div_req.nbits = CNT_W'(SW);
                div_dvd       = {sum_reg, {(DVD_W-SW){1'b0}}};
                div_dvs       = DVS_W'(held_reg - HW'(1));
            end
            ST_WDIV: begin
                // weight = 2^32 / cumulative time
                div_req.start = !pend_reg;
                div_req.nbits = CNT_W'(33);
                div_dvd       = {33'h1_0000_0000, {(DVD_W-33){1'b0}}};
                div_dvs       = DVS_W'(tsum_reg);
            end
            ST_ML: begin
                // mean lifetime of one sample
                div_req.start = !pend_reg && (rd_count != '0);
                div_req.nbits = CNT_W'(40);
                div_dvd       = {rd_life, {(DVD_W-40){1'b0}}};
                div_dvs       = {48'b0, rd_count};
            end
            ST_MULC: begin
                mul_req.start = !pend_reg;
                mul_req.nbits = CNT_W'(16);
                mul_b         = {24'b0, rd_count};
            end
            ST_MULL: begin
                mul_req.start = !pend_reg;
                mul_req.nbits = CNT_W'(40);
                mul_b         = ml_reg;
            end
            ST_A: begin
                // rsum * 2^32 / wsum
                div_req.start = !pend_reg && (wsum_reg != '0);
                div_req.nbits = CNT_W'(DVD_W);
                div_dvd       = {rsum_reg, 32'b0};
                div_dvs       = wsum_reg;
            end
            ST_RATE: begin
                div_req.start = !pend_reg && (mean_reg != '0);
                div_req.nbits = CNT_W'(64);
                div_dvd       = {a_reg, 32'b0};
                div_dvs       = {32'b0, mean_reg};
            end
            ST_LIFE: begin
                div_req.start = !pend_reg;
                div_req.nbits = CNT_W'(64);
                div_dvd       = {lsum_reg, 32'b0};
                div_dvs       = wsum_reg;
            end
            ST_VOL: begin
                mul_req.start = !pend_reg;
                mul_req.nbits = CNT_W'(32);
                mul_a         = rate_reg;
                mul_b         = {8'b0, life_reg};
            end
            default: begin
            end
        endcase
    end

    // datapath updates
    always_comb begin
        logic [64:0] s1;
        logic [64:0] s2;
        logic [63:0] pv;

        pend_next = pend_reg;
        idx_next  = idx_reg;
        held_next = held_reg;
        open_next = open_reg;
        sat_next  = sat_reg;
        est_next  = est_reg;
        sum_next  = sum_reg;
        mean_next = mean_reg;
        tsum_next = tsum_reg;
        w_next    = w_reg;
        ml_next   = ml_reg;
        wsum_next = wsum_reg;
        rsum_next = rsum_reg;
        lsum_next = lsum_reg;
        a_next    = a_reg;
        rate_next = rate_reg;
        life_next = life_reg;
        vol_next  = vol_reg;
        s1        = '0;
        s2        = '0;
        pv        = '0;

        if (div_req.start || mul_req.start) begin
            pend_next = 1'b1;
        end else if (unit_done) begin
            pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    open_next = push ? 32'b0 : t_sat;
                    held_next = held_after;
                    sat_next  = t_ovf;
                    est_next  = held_after > HW'(1);
                    idx_next  = IW'(1);
                    sum_next  = '0;
                    rate_next = '0;
                    life_next = '0;
                    vol_next  = '0;
                end
            end
            ST_SUM: begin
                sum_next = sum_reg + SW'(rd_interval);
                if (!idx_last) idx_next = idx_reg + IW'(1);
            end
            ST_MEAN: begin
                if (unit_done) begin
                    mean_next = div_q[31:0];
                    // open interval counts only when longer than the mean
                    idx_next  = (open_reg > div_q[31:0]) ? IW'(0) : IW'(1);
                    tsum_next = '0;
                    wsum_next = '0;
                    rsum_next = '0;
                    lsum_next = '0;
                end
            end
            ST_TACC: begin
                tsum_next = tsum_new;
                if (tsum_new == '0) begin
                    w_next   = 33'h1_0000_0000;
                    sat_next = 1'b1;
                end
            end
            ST_WDIV: if (unit_done) w_next = div_q[32:0];
            ST_ML: begin
                if (rd_count == '0) ml_next = '0;
                else if (unit_done) ml_next = div_q[39:0];
            end
            ST_MULC: begin
                if (unit_done) begin
                    s1        = add_sat(rsum_reg, mul_p[63:0]);
                    s2        = add_sat(wsum_reg, {31'b0, w_reg});
                    rsum_next = s1[63:0];
                    wsum_next = s2[63:0];
                    sat_next  = sat_reg || s1[64] || s2[64];
                end
            end
            ST_MULL: begin
                if (unit_done) begin
                    pv        = (mul_p[79:64] != '0) ? {64{1'b1}} : mul_p[63:0];
                    s1        = add_sat(lsum_reg, pv);
                    lsum_next = s1[63:0];
                    sat_next  = sat_reg || s1[64] || (mul_p[79:64] != '0);
                    if (!idx_last) idx_next = idx_reg + IW'(1);
                end
            end
            ST_A: begin
                if (unit_done) begin
                    if (div_q[95:64] != '0) begin
                        a_next   = {64{1'b1}};
                        sat_next = 1'b1;
                    end else begin
                        a_next = div_q[63:0];
                    end
                end
            end
            ST_RATE: begin
                if (mean_reg == '0) begin
                    rate_next = {40{1'b1}};
                    sat_next  = 1'b1;
                end else if (unit_done) begin
                    if (div_q[95:40] != '0) begin
                        rate_next = {40{1'b1}};
                        sat_next  = 1'b1;
                    end else begin
                        rate_next = div_q[39:0];
                    end
                end
            end
            ST_LIFE: begin
                if (unit_done) begin
                    if (div_q[95:32] != '0) begin
                        life_next = {32{1'b1}};
                        sat_next  = 1'b1;
                    end else begin
                        life_next = div_q[31:0];
                    end
                end
            end
            ST_VOL: begin
                if (unit_done) begin
                    if (mul_p[79:64] != '0) begin
                        vol_next = {32{1'b1}};
                        sat_next = 1'b1;
                    end else begin
                        vol_next = mul_p[63:32];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            held_reg    <= '0;
            open_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            held_reg  <= held_next;
            open_reg  <= open_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and result register
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        sat_reg  <= sat_next;
        est_reg  <= est_next;
        sum_reg  <= sum_next;
        mean_reg <= mean_next;
        tsum_reg <= tsum_next;
        w_reg    <= w_next;
        ml_reg   <= ml_next;
        wsum_reg <= wsum_next;
        rsum_reg <= rsum_next;
        lsum_reg <= lsum_next;
        a_reg    <= a_next;
        rate_reg <= rate_next;
        life_reg <= life_next;
        vol_reg  <= vol_next;
        if (state_reg == ST_DONE && out_free) begin
            out_rate_reg <= rate_reg;
            out_life_reg <= life_reg;
            out_vol_reg  <= vol_reg;
            out_est_reg  <= est_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_rate_estimate   = out_rate_reg;
    assign m_life_estimate   = out_life_reg;
    assign m_volume_estimate = out_vol_reg;
    assign m_estimate_valid  = out_est_reg;
    assign m_saturated       = out_sat_reg;

endmodule

// File: tb/sv/tb_spawn_rate_estimator.sv
// self-checking testbench for the spawn rate estimator
`timescale 1ns / 1ps

module tb_spawn_rate_estimator;
    import sre_pkg::*;

    localparam int DEPTH      = 8;
    localparam int N_RANDOM   = 1720;
    localparam int MAX_CYCLES = 12_000_000;
    localparam int LONG_HOLD  = 4000;
    localparam int HOLD_AT    = 40;
    localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP40 = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [63:0] TOP32 = 64'h0000_0000_FFFF_FFFF;

    // one result of the block
    typedef struct packed {
        logic [39:0] rate;
        logic [31:0] life;
        logic [31:0] volume;
        logic        valid;
        logic        sat;
    } estimate_t;

    // one tick request, with an optional typed-in expectation
    typedef struct packed {
        logic [23:0] dt;
        logic [15:0] count;
        logic [39:0] lifetime;
        logic        typed;
        estimate_t   want;
    } tick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_elapsed_time = '0;
    logic [15:0] s_spawned_count = '0;
    logic [39:0] s_lifetime_total = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_rate_estimate;
    logic [31:0] m_life_estimate;
    logic [31:0] m_volume_estimate;
    logic        m_estimate_valid;
    logic        m_saturated;

    spawn_rate_estimator #(.HISTORY_DEPTH(DEPTH)) dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mirror of the block's history
    logic [31:0] hist_interval [DEPTH];
    logic [15:0] hist_count [DEPTH];
    logic [39:0] hist_lifetime [DEPTH];
    int          hist_held;
    logic [31:0] open_time;

    estimate_t pending_estimates[$];
    int        errors = 0;
    int        received = 0;
    int        cycles = 0;
    bit        stimulus_done = 1'b0;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            inout bit sat);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            sat = 1'b1;
            return ALL64;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b,
                                            inout bit sat);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] != 0) begin
            sat = 1'b1;
            return ALL64;
        end
        return p[63:0];
    endfunction

    // floor(num * 2^sh / den), clipped to lim
    function automatic logic [63:0] scaled_quotient(input logic [63:0] num, input int sh,
                                                    input logic [63:0] den,
                                                    input logic [63:0] lim, inout bit sat);
        logic [127:0] q;
        if (den == 0) begin
            sat = 1'b1;
            return lim;
        end
        q = ({64'd0, num} << sh) / {64'd0, den};
        if (q > {64'd0, lim}) begin
            sat = 1'b1;
            return lim;
        end
        return q[63:0];
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < DEPTH; i++) begin
            hist_interval[i] = '0;
            hist_count[i] = '0;
            hist_lifetime[i] = '0;
        end
        hist_held = 0;
        open_time = '0;
    endfunction

    // advance the history by one tick and work out the estimate it yields
    function automatic estimate_t estimate_tick(input logic [23:0] dt, input logic [15:0] cnt,
                                                input logic [39:0] lt);
        estimate_t   e;
        bit          sat, ovf;
        logic [32:0] t;
        logic [63:0] sum, mean, tsum, wsum, rsum, lsum, w, ml, a, rate, life, p;
        int          first;
        e = '0;
        sat = 1'b0;
        t = {1'b0, open_time} + dt;
        if (t[32]) begin
            sat = 1'b1;
            t = 33'h0_FFFF_FFFF;
        end
        open_time = t[31:0];
        if (cnt != 0) begin
            if (hist_held >= DEPTH) hist_held = DEPTH - 1;
            if (hist_held > 0) hist_interval[0] = open_time;
            for (int i = hist_held; i > 0; i--) begin
                hist_interval[i] = hist_interval[i-1];
                hist_count[i] = hist_count[i-1];
                hist_lifetime[i] = hist_lifetime[i-1];
            end
            hist_interval[0] = '0;
            hist_count[0] = cnt;
            hist_lifetime[0] = lt;
            hist_held++;
            open_time = '0;
        end
        if (hist_held > 1) begin
            e.valid = 1'b1;
            hist_interval[0] = open_time;
            sum = 0;
            for (int i = 1; i < hist_held; i++) sum += hist_interval[i];
            mean = sum / (hist_held - 1);
            // the open interval only counts once it outlasts the mean
            first = ({32'd0, open_time} > mean) ? 0 : 1;
            tsum = 0; wsum = 0; rsum = 0; lsum = 0; rate = 0; life = 0;
            for (int i = first; i < hist_held; i++) begin
                tsum += hist_interval[i];
                if (tsum == 0) begin
                    w = 64'd1 << 32;
                    sat = 1'b1;
                end else begin
                    w = (64'd1 << 32) / tsum;
                end
                ml = (hist_count[i] != 0) ? hist_lifetime[i] / hist_count[i] : 0;
                wsum = sat_add(wsum, w, sat);
                // products first so their clamp flag is kept
                p = sat_mul(w, {48'd0, hist_count[i]}, sat);
                rsum = sat_add(rsum, p, sat);
                p = sat_mul(w, ml, sat);
                lsum = sat_add(lsum, p, sat);
            end
            if (wsum > 0) begin
                a = scaled_quotient(rsum, 32, wsum, ALL64, sat);
                rate = scaled_quotient(a, 0, mean, TOP40, sat);
                life = scaled_quotient(lsum, 0, wsum, TOP32, sat);
            end
            ovf = 1'b0;
            p = sat_mul(rate, life, ovf);
            if (ovf || (p >> 32) > TOP32) begin
                e.volume = '1;
                sat = 1'b1;
            end else begin
                e.volume = p[63:32];
            end
            e.rate = rate[39:0];
            e.life = life[31:0];
        end
        e.sat = sat;
        return e;
    endfunction

    function automatic tick_t make_tick(input logic [23:0] dt, input logic [15:0] cnt,
                                        input logic [39:0] lt);
        tick_t k;
        k = '0;
        k.dt = dt;
        k.count = cnt;
        k.lifetime = lt;
        return k;
    endfunction

    // typed-in rows: short history gives zeros, only the open interval flags
    function automatic tick_t make_typed(input logic [23:0] dt, input logic [15:0] cnt,
                                         input logic [39:0] lt, input logic sat);
        tick_t k;
        k = make_tick(dt, cnt, lt);
        k.typed = 1'b1;
        k.want.sat = sat;
        return k;
    endfunction

    // random tick, mostly frame-like with a share of full-range noise
    function automatic tick_t random_tick();
        logic [23:0] dt;
        logic [15:0] cnt;
        logic [39:0] lt;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 70) dt = 24'($urandom_range(500, 3000));
        else if (r < 80) dt = '0;
        else dt = 24'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) cnt = '0;
        else if (r < 90) cnt = 16'($urandom_range(1, 200));
        else cnt = 16'($urandom);
        if ($urandom_range(0, 99) < 70) lt = 40'(cnt) * 40'($urandom_range(0, 5 << 16));
        else lt = 40'({$urandom, $urandom});
        return make_tick(dt, cnt, lt);
    endfunction

    tick_t directed_ticks[$];
    tick_t random_ticks[$];

    // sender: every request waits a random gap, valid holds until accepted
    task automatic send_ticks(input tick_t list[$]);
        int gap;
        foreach (list[n]) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_elapsed_time <= list[n].dt;
            s_spawned_count <= list[n].count;
            s_lifetime_total <= list[n].lifetime;
            @(posedge aclk);
            while (!(s_valid && s_ready)) @(posedge aclk);
            // the request is taken at this edge, predict its result now
            if (list[n].typed) begin
                void'(estimate_tick(list[n].dt, list[n].count, list[n].lifetime));
                pending_estimates.push_back(list[n].want);
            end else begin
                pending_estimates.push_back(
                    estimate_tick(list[n].dt, list[n].count, list[n].lifetime));
            end
        end
        s_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got %h want %h", received, what, got, want);
        errors++;
    endtask

    initial begin
        clear_history();
        // reset state and zero tick, then first sample, then extremes
        directed_ticks.push_back(make_typed(24'd0, 16'd0, 40'd0, 1'b0));
        directed_ticks.push_back(make_typed(24'd1092, 16'd0, 40'd0, 1'b0));
        directed_ticks.push_back(make_typed(24'hFFFFFF, 16'hFFFF, '1, 1'b0));
        directed_ticks.push_back(make_typed(24'hFFFFFF, 16'd0, 40'h55_5555_5555, 1'b0));
        // second sample arrives: estimates become valid
        directed_ticks.push_back(make_tick(24'd1092, 16'd1, 40'd1 << 16));
        directed_ticks.push_back(make_tick(24'd1092, 16'd0, 40'hAA_AAAA_AAAA));
        directed_ticks.push_back(make_tick(24'd1092, 16'd10, 40'd30 << 16));
        // zero elapsed spawns: zero cumulative time
        directed_ticks.push_back(make_tick(24'd0, 16'd3, 40'd6 << 16));
        directed_ticks.push_back(make_tick(24'd0, 16'd3, 40'd6 << 16));
        directed_ticks.push_back(make_tick(24'd0, 16'd0, 40'd0));
        // long open interval exceeds the mean
        directed_ticks.push_back(make_tick(24'hFFFFFF, 16'd0, 40'd0));
        directed_ticks.push_back(make_tick(24'd2000, 16'hFFFF, '1));
        directed_ticks.push_back(make_tick(24'd1, 16'd1, 40'd0));
        // fill the history past its depth
        for (int i = 0; i < DEPTH + 2; i++)
            directed_ticks.push_back(make_tick(24'd1092 + 24'(i), 16'd5, 40'd5 << 17));

        for (int i = 0; i < N_RANDOM; i++) begin
            // one burst of long idle ticks to saturate the open interval
            if (i == N_RANDOM / 2) begin
                for (int j = 0; j < 260; j++)
                    random_ticks.push_back(
                        make_tick(24'hFFFFFF, 16'd0, 40'({$urandom, $urandom})));
            end
            random_ticks.push_back(random_tick());
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_ticks(directed_ticks);
        send_ticks(random_ticks);
        stimulus_done = 1'b1;
    end

    // receiver: random stalls per result, plus one long hold to back up the block
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (received == HOLD_AT) gap = LONG_HOLD;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // result checker against the oldest expectation
    always @(posedge aclk) begin
        estimate_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_estimates.size() == 0) begin
                $display("unexpected result %0d with nothing pending", received);
                errors++;
            end else begin
                want = pending_estimates.pop_front();
                if (m_rate_estimate !== want.rate)
                    report_mismatch("rate", 64'(m_rate_estimate), 64'(want.rate));
                if (m_life_estimate !== want.life)
                    report_mismatch("life", 64'(m_life_estimate), 64'(want.life));
                if (m_volume_estimate !== want.volume)
                    report_mismatch("volume", 64'(m_volume_estimate), 64'(want.volume));
                if (m_estimate_valid !== want.valid)
                    report_mismatch("valid", 64'(m_estimate_valid), 64'(want.valid));
                if (m_saturated !== want.sat)
                    report_mismatch("saturated", 64'(m_saturated), 64'(want.sat));
            end
            received++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // end of run: drain, let a stray result show up, then judge
    initial begin
        wait (stimulus_done);
        while (pending_estimates.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (errors == 0 && pending_estimates.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
